FILE: hw/rtl/pba_pkg.sv
// pba_pkg: shared types and constants of the payload budget accounting block
// used by pba_ctrl, pba_dp and payload_budget_accounting; no dependencies
package pba_pkg;

    localparam int MAX_DISTINCT_DEF = 256;
    localparam int ID_W  = 11;
    localparam int VAL_W = 64;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_BUDGET   = 2'd2,
        ST_CAPACITY = 2'd3
    } t_status;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_SUM    = 2'd1,
        S_SCAN   = 2'd2,
        S_COMMIT = 2'd3
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic sum;
        logic scan;
        logic commit;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic scan_done;
        logic out_busy;
    } t_sts;

endpackage

FILE: hw/rtl/pba_ram.sv
// pba_ram: generic one-write one-read RAM with registered read data
// no dependencies
module pba_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 256
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/pba_ctrl.sv
// pba_ctrl: sequencer for accept, sum, identifier scan and commit
// depends on pba_pkg
module pba_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  pba_pkg::t_sts i_sts,
    output logic          o_in_ready,
    output pba_pkg::t_cmd o_cmd
);

    pba_pkg::t_state r_state;
    pba_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pba_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            pba_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = pba_pkg::S_SUM;
                end
            end
            pba_pkg::S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = pba_pkg::S_SCAN;
            end
            pba_pkg::S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = pba_pkg::S_COMMIT;
                end
            end
            pba_pkg::S_COMMIT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.commit = 1'b1;
                    n_state      = pba_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pba_pkg::S_IDLE;
            end
        endcase
    end

endmodule

FILE: hw/rtl/pba_dp.sv
// pba_dp: totals, peak, identifier list and result register
// depends on pba_pkg and pba_ram
module pba_dp #(
    parameter int MAX_DISTINCT = pba_pkg::MAX_DISTINCT_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  pba_pkg::t_cmd                        i_cmd,
    output pba_pkg::t_sts                        o_sts,
    input  logic [pba_pkg::VAL_W-1:0]            i_budget,
    input  logic [pba_pkg::ID_W-1:0]             i_tensor_id,
    input  logic [pba_pkg::VAL_W-1:0]            i_byte_amount,
    input  logic [pba_pkg::VAL_W-1:0]            i_block_amount,
    input  logic [pba_pkg::VAL_W-1:0]            i_materialized_size,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [1:0]                           o_status,
    output logic [pba_pkg::VAL_W-1:0]            o_bytes_total,
    output logic [pba_pkg::VAL_W-1:0]            o_blocks_total,
    output logic [pba_pkg::VAL_W-1:0]            o_largest_materialized,
    output logic [$clog2(MAX_DISTINCT+1)-1:0]    o_distinct_count
);

    localparam int CW = $clog2(MAX_DISTINCT + 1);
    localparam int AW = (MAX_DISTINCT > 1) ? $clog2(MAX_DISTINCT) : 1;
    localparam int VW = pba_pkg::VAL_W;

    // latched record
    logic [pba_pkg::ID_W-1:0] r_id;
    logic [VW-1:0]            r_bytes_in;
    logic [VW-1:0]            r_blocks_in;
    logic [VW-1:0]            r_mat_in;

    // accounting state
    logic [VW-1:0] r_byte_sum;
    logic [VW-1:0] r_block_sum;
    logic [VW-1:0] r_peak;
    logic [CW-1:0] r_count;

    // sums and flags of the record in flight
    logic [VW-1:0] r_next_bytes;
    logic [VW-1:0] r_next_blocks;
    logic [VW-1:0] r_next_peak;
    logic          r_byte_c;
    logic          r_block_c;
    logic          r_over;

    // scan state
    logic [CW-1:0] r_ptr;
    logic          r_pend;
    logic          r_hit;

    // result register
    logic          r_out_valid;
    logic [1:0]    r_status;
    logic [VW-1:0] r_out_bytes;
    logic [VW-1:0] r_out_blocks;
    logic [VW-1:0] r_out_peak;
    logic [CW-1:0] r_out_count;

    logic                     w_rd_en;
    logic                     w_we;
    logic [pba_pkg::ID_W-1:0] w_rdata;
    logic                     w_full;
    pba_pkg::t_status         n_status;
    logic                     n_ok;

    assign w_rd_en = i_cmd.scan && (r_ptr < r_count);
    assign w_full  = (r_count >= CW'(MAX_DISTINCT));

    // status in check order
    always_comb begin
        if (r_byte_c) begin
            n_status = pba_pkg::ST_OVERFLOW;
        end else if (r_over) begin
            n_status = pba_pkg::ST_BUDGET;
        end else if (r_block_c) begin
            n_status = pba_pkg::ST_OVERFLOW;
        end else if (!r_hit && w_full) begin
            n_status = pba_pkg::ST_CAPACITY;
        end else begin
            n_status = pba_pkg::ST_OK;
        end
    end

    assign n_ok = (n_status == pba_pkg::ST_OK);
    assign w_we = i_cmd.commit && n_ok && !r_hit;

    pba_ram #(
        .WIDTH (pba_pkg::ID_W),
        .DEPTH (MAX_DISTINCT)
    ) u_ids (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (r_id),
        .i_re    (w_rd_en),
        .i_raddr (r_ptr[AW-1:0]),
        .o_rdata (w_rdata)
    );

    // record latch, sums and budget compare
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_id        <= i_tensor_id;
            r_bytes_in  <= i_byte_amount;
            r_blocks_in <= i_block_amount;
            r_mat_in    <= i_materialized_size;
        end
        if (i_cmd.sum) begin
            {r_byte_c, r_next_bytes}   <= {1'b0, r_byte_sum} + {1'b0, r_bytes_in};
            {r_block_c, r_next_blocks} <= {1'b0, r_block_sum} + {1'b0, r_blocks_in};
            r_next_peak <= (r_mat_in > r_peak) ? r_mat_in : r_peak;
        end
        r_over <= (r_next_bytes > i_budget);
    end

    // identifier scan, one stored entry a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr  <= '0;
            r_pend <= 1'b0;
            r_hit  <= 1'b0;
        end else if (i_cmd.sum) begin
            r_ptr  <= '0;
            r_pend <= 1'b0;
            r_hit  <= 1'b0;
        end else if (i_cmd.scan) begin
            r_pend <= w_rd_en;
            if (w_rd_en) begin
                r_ptr <= r_ptr + CW'(1);
            end
            if (r_pend && (w_rdata == r_id)) begin
                r_hit <= 1'b1;
            end
        end
    end

    // accounting state update on an accepted record
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_sum  <= '0;
            r_block_sum <= '0;
            r_peak      <= '0;
            r_count     <= '0;
        end else if (i_cmd.commit && n_ok) begin
            r_byte_sum  <= r_next_bytes;
            r_block_sum <= r_next_blocks;
            r_peak      <= r_next_peak;
            if (!r_hit) begin
                r_count <= r_count + CW'(1);
            end
        end
    end

    // result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_status     <= n_status;
            r_out_bytes  <= n_ok ? r_next_bytes  : r_byte_sum;
            r_out_blocks <= n_ok ? r_next_blocks : r_block_sum;
            r_out_peak   <= n_ok ? r_next_peak   : r_peak;
            r_out_count  <= (n_ok && !r_hit) ? (r_count + CW'(1)) : r_count;
        end
    end

    assign o_sts.scan_done = (r_ptr >= r_count) && !r_pend;
    assign o_sts.out_busy  = r_out_valid && !i_ready;

    assign o_valid                = r_out_valid;
    assign o_status               = r_status;
    assign o_bytes_total          = r_out_bytes;
    assign o_blocks_total         = r_out_blocks;
    assign o_largest_materialized = r_out_peak;
    assign o_distinct_count       = r_out_count;

endmodule

FILE: hw/rtl/payload_budget_accounting.sv
// payload_budget_accounting: top level with budget register and apb port
// depends on pba_pkg, pba_ctrl, pba_dp (and pba_ram through pba_dp)
//
// channel   direction  handshake           payload
// input     in         i_valid / o_ready   tensor_id, byte_amount, block_amount,
//                                          materialized_size
// result    out        o_valid / i_ready   status, bytes_total, blocks_total,
//                                          largest_materialized, distinct_count
// config    in         psel/penable/pwrite paddr, pwdata, prdata (64 bit)
//
// a record passes from its transfer to the next ready through a sum step,
// a scan of the stored identifiers through the single read port
// of the identifier ram (one entry a cycle, then a last compare),
// and a commit step. reset is synchronous, active low, and clears totals,
// peak, count, budget and handshake state; the identifier ram is not cleared.
// a waiting result does not block the next input transfer, only its commit.
module payload_budget_accounting #(
    parameter int MAX_DISTINCT = pba_pkg::MAX_DISTINCT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input channel
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [pba_pkg::ID_W-1:0]          i_tensor_id,
    input  logic [pba_pkg::VAL_W-1:0]         i_byte_amount,
    input  logic [pba_pkg::VAL_W-1:0]         i_block_amount,
    input  logic [pba_pkg::VAL_W-1:0]         i_materialized_size,
    // result channel
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [1:0]                        o_status,
    output logic [pba_pkg::VAL_W-1:0]         o_bytes_total,
    output logic [pba_pkg::VAL_W-1:0]         o_blocks_total,
    output logic [pba_pkg::VAL_W-1:0]         o_largest_materialized,
    output logic [$clog2(MAX_DISTINCT+1)-1:0] o_distinct_count,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [3:0]                        paddr,
    input  logic [63:0]                       pwdata,
    output logic [63:0]                       prdata,
    output logic                              pready
);

    localparam logic [3:0] ADDR_BUDGET = 4'd0;

    logic [pba_pkg::VAL_W-1:0] r_budget;
    pba_pkg::t_cmd             w_cmd;
    pba_pkg::t_sts             w_sts;

    assign pready = 1'b1;

    // budget register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_budget <= '0;
        end else if (psel && penable && pwrite && (paddr == ADDR_BUDGET)) begin
            r_budget <= pwdata;
        end
    end

    // register read
    assign prdata = (paddr == ADDR_BUDGET) ? r_budget : '0;

    pba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .i_sts      (w_sts),
        .o_in_ready (o_ready),
        .o_cmd      (w_cmd)
    );

    pba_dp #(
        .MAX_DISTINCT (MAX_DISTINCT)
    ) u_dp (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cmd                  (w_cmd),
        .o_sts                  (w_sts),
        .i_budget               (r_budget),
        .i_tensor_id            (i_tensor_id),
        .i_byte_amount          (i_byte_amount),
        .i_block_amount         (i_block_amount),
        .i_materialized_size    (i_materialized_size),
        .o_valid                (o_valid),
        .i_ready                (i_ready),
        .o_status               (o_status),
        .o_bytes_total          (o_bytes_total),
        .o_blocks_total         (o_blocks_total),
        .o_largest_materialized (o_largest_materialized),
        .o_distinct_count       (o_distinct_count)
    );

`ifndef SYNTHESIS
    // one record at a time: ready drops after an input transfer
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input accepted while a record is in flight");

    // the distinct count never passes the list capacity
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_distinct_count <= ($clog2(MAX_DISTINCT+1))'(MAX_DISTINCT)))
        else $error("distinct count beyond capacity");

    // an accepted record never leaves the byte total over budget
    a_ok_in_budget: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == pba_pkg::ST_OK)) |-> (o_bytes_total <= r_budget))
        else $error("ok result with byte total over budget");

    // a new result only appears once the previous one is gone
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_bytes_total)))
        else $error("pending result overwritten");
`endif

endmodule

FILE: tb/payload_budget_accounting_test.sv
// payload_budget_accounting_test: self-checking bench for the payload budget accounting block
// depends on pba_pkg and the payload_budget_accounting rtl; drives access records and apb
// budget writes, and checks every result against the directed plan or its own accounting model
module payload_budget_accounting_test;

    localparam int ID_W = pba_pkg::ID_W;
    localparam int VAL_W = pba_pkg::VAL_W;
    localparam int MAX_IDS = pba_pkg::MAX_DISTINCT_DEF;
    localparam int CNT_W = $clog2(MAX_IDS + 1);
    localparam logic [3:0] ADDR_BUDGET = 4'h0;
    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_LIMIT = 20000;
    localparam int NUM_PHASES = 10;

    // one access record as offered on the input channel
    typedef struct packed {
        logic [ID_W-1:0]  tensor_id;
        logic [VAL_W-1:0] byte_amount;
        logic [VAL_W-1:0] block_amount;
        logic [VAL_W-1:0] materialized_size;
    } t_access;

    // one accounting result as seen on the result channel
    typedef struct packed {
        pba_pkg::t_status status;
        logic [VAL_W-1:0] bytes_total;
        logic [VAL_W-1:0] blocks_total;
        logic [VAL_W-1:0] largest_materialized;
        logic [CNT_W-1:0] distinct_count;
    } t_tally;

    typedef enum logic {
        ROW_RECORD,
        ROW_BUDGET
    } t_row_kind;

    // one line of the directed plan
    typedef struct packed {
        t_row_kind   kind;
        t_access     rec;
        logic [63:0] budget;
        bit          typed;
        t_tally      want;
    } t_plan_row;

    typedef enum logic [2:0] {
        BUD_MAX,
        BUD_HEADROOM,
        BUD_EXACT,
        BUD_RANDOM,
        BUD_ZERO
    } t_budget_mode;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic [ID_W-1:0]   i_tensor_id;
    logic [VAL_W-1:0]  i_byte_amount;
    logic [VAL_W-1:0]  i_block_amount;
    logic [VAL_W-1:0]  i_materialized_size;
    logic              o_valid;
    logic              i_ready;
    logic [1:0]        o_status;
    logic [VAL_W-1:0]  o_bytes_total;
    logic [VAL_W-1:0]  o_blocks_total;
    logic [VAL_W-1:0]  o_largest_materialized;
    logic [CNT_W-1:0]  o_distinct_count;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [3:0]        paddr;
    logic [63:0]       pwdata;
    logic [63:0]       prdata;
    logic              pready;

    payload_budget_accounting dut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_valid                (i_valid),
        .o_ready                (o_ready),
        .i_tensor_id            (i_tensor_id),
        .i_byte_amount          (i_byte_amount),
        .i_block_amount         (i_block_amount),
        .i_materialized_size    (i_materialized_size),
        .o_valid                (o_valid),
        .i_ready                (i_ready),
        .o_status               (o_status),
        .o_bytes_total          (o_bytes_total),
        .o_blocks_total         (o_blocks_total),
        .o_largest_materialized (o_largest_materialized),
        .o_distinct_count       (o_distinct_count),
        .psel                   (psel),
        .penable                (penable),
        .pwrite                 (pwrite),
        .paddr                  (paddr),
        .pwdata                 (pwdata),
        .prdata                 (prdata),
        .pready                 (pready)
    );

    // accounting model state
    logic [63:0]     budget_limit = '0;
    logic [63:0]     charged_bytes = '0;
    logic [63:0]     charged_blocks = '0;
    logic [63:0]     peak_size = '0;
    logic [ID_W-1:0] id_list [MAX_IDS];
    int              id_count = 0;

    // results still owed by the block, oldest first
    t_tally          pending_tallies [$];
    t_tally          oldest_tally;

    // run bookkeeping
    int  fail_count = 0;
    int  records_sent = 0;
    int  results_checked = 0;
    int  input_stall_cycles = 0;
    int  status_seen [4] = '{0, 0, 0, 0};
    bit  idle_on = 1'b0;
    bit  hold_rx_req = 1'b0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // charge one record against the model, returning the result it should produce
    function automatic t_tally charge_access(input t_access a);
        logic [64:0] wide_bytes;
        logic [64:0] wide_blocks;
        bit          known;
        t_tally      t;
        wide_bytes = {1'b0, charged_bytes} + {1'b0, a.byte_amount};
        wide_blocks = {1'b0, charged_blocks} + {1'b0, a.block_amount};
        known = 1'b0;
        t.status = pba_pkg::ST_OK;
        // checks in priority order; any failure leaves the state untouched
        if (wide_bytes[64]) begin
            t.status = pba_pkg::ST_OVERFLOW;
        end else if (wide_bytes[63:0] > budget_limit) begin
            t.status = pba_pkg::ST_BUDGET;
        end else if (wide_blocks[64]) begin
            t.status = pba_pkg::ST_OVERFLOW;
        end else begin
            for (int k = 0; k < id_count; k++) begin
                if (id_list[k] == a.tensor_id) known = 1'b1;
            end
            if (!known && id_count >= MAX_IDS) begin
                t.status = pba_pkg::ST_CAPACITY;
            end else begin
                charged_bytes = wide_bytes[63:0];
                charged_blocks = wide_blocks[63:0];
                if (a.materialized_size > peak_size) peak_size = a.materialized_size;
                if (!known) begin
                    id_list[id_count] = a.tensor_id;
                    id_count++;
                end
            end
        end
        t.bytes_total = charged_bytes;
        t.blocks_total = charged_blocks;
        t.largest_materialized = peak_size;
        t.distinct_count = CNT_W'(id_count);
        return t;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // random record: mostly small well-formed charges, some deliberate overflows and noise
    function automatic t_access make_access();
        t_access     a;
        logic [63:0] headroom;
        int          pick;
        headroom = (budget_limit >= charged_bytes) ? budget_limit - charged_bytes : '0;
        pick = $urandom_range(0, 9);
        if (id_count > 0 && $urandom_range(0, 1) == 1) begin
            a.tensor_id = id_list[$urandom_range(0, id_count - 1)];
        end else begin
            a.tensor_id = ID_W'($urandom);
        end
        a.byte_amount = rand64() >> $urandom_range(26, 63);
        if ($urandom_range(0, 7) == 0) a.byte_amount = '0;
        a.block_amount = rand64() >> $urandom_range(20, 63);
        a.materialized_size = rand64() >> $urandom_range(4, 63);
        if (pick == 0 && !headroom[63]) begin
            // noise far past whatever budget is left
            a.byte_amount = rand64() | {1'b1, 63'd0};
            a.block_amount = rand64();
            a.materialized_size = rand64();
        end else if (pick == 1) begin
            // byte total carried just past 64 bits
            a.byte_amount = ~charged_bytes + 64'd1 + 64'($urandom_range(0, 255));
        end else if (pick == 2) begin
            // block total carried just past 64 bits
            a.block_amount = ~charged_blocks + 64'd1 + 64'($urandom_range(0, 255));
        end
        return a;
    endfunction

    function automatic t_plan_row record_row(input bit typed, input logic [ID_W-1:0] id,
                                             input logic [63:0] bytes,
                                             input logic [63:0] blocks,
                                             input logic [63:0] mat,
                                             input pba_pkg::t_status st,
                                             input logic [63:0] bt, input logic [63:0] kt,
                                             input logic [63:0] pk, input int cnt);
        t_plan_row r;
        r.kind = ROW_RECORD;
        r.rec = '{tensor_id: id, byte_amount: bytes, block_amount: blocks,
                  materialized_size: mat};
        r.budget = '0;
        r.typed = typed;
        r.want = '{status: st, bytes_total: bt, blocks_total: kt,
                   largest_materialized: pk, distinct_count: CNT_W'(cnt)};
        return r;
    endfunction

    function automatic t_plan_row budget_row(input logic [63:0] value);
        t_plan_row r;
        r = '0;
        r.kind = ROW_BUDGET;
        r.budget = value;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
        fail_count++;
    endtask

    // offer one record and hold it until the transfer; valid stays high on return
    task automatic offer_record(input t_access a, input bit typed, input t_tally want);
        t_tally predicted;
        i_valid <= 1'b1;
        i_tensor_id <= a.tensor_id;
        i_byte_amount <= a.byte_amount;
        i_block_amount <= a.block_amount;
        i_materialized_size <= a.materialized_size;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predicted = charge_access(a);
        pending_tallies.push_back(typed ? want : predicted);
        records_sent++;
    endtask

    // random sender gap
    task automatic idle_gap();
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
    endtask

    // drain the block, then write the budget and read it back
    task automatic write_budget(input logic [63:0] value);
        i_valid <= 1'b0;
        while (pending_tallies.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_BUDGET;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        budget_limit = value;
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== value) report_mismatch("budget readback", value, prdata);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // result sink with random stalls and one long hold-off on request
    initial begin : result_sink
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_rx_req) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_rx_req = 1'b0;
                i_ready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
                i_ready <= 1'b1;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_ready) input_stall_cycles++;
        if (i_rst_n && o_valid && i_ready) begin
            status_seen[o_status]++;
            if (pending_tallies.size() == 0) begin
                $display("%0t: result transfer with nothing expected, status %0d", $time,
                         o_status);
                fail_count++;
            end else begin
                oldest_tally = pending_tallies.pop_front();
                results_checked++;
                if (o_status !== oldest_tally.status)
                    report_mismatch("status", 64'(oldest_tally.status), 64'(o_status));
                if (o_bytes_total !== oldest_tally.bytes_total)
                    report_mismatch("bytes_total", oldest_tally.bytes_total, o_bytes_total);
                if (o_blocks_total !== oldest_tally.blocks_total)
                    report_mismatch("blocks_total", oldest_tally.blocks_total, o_blocks_total);
                if (o_largest_materialized !== oldest_tally.largest_materialized)
                    report_mismatch("largest_materialized", oldest_tally.largest_materialized,
                                    o_largest_materialized);
                if (o_distinct_count !== oldest_tally.distinct_count)
                    report_mismatch("distinct_count", 64'(oldest_tally.distinct_count),
                                    64'(o_distinct_count));
            end
        end
    end

    // stimulus
    initial begin : stimulus
        t_plan_row    plan [$];
        t_budget_mode mode;
        int           n_items;
        int           wait_cycles;
        logic [63:0]  new_budget;
        t_access      a;
        t_tally       none;

        none = '0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_tensor_id <= '0;
        i_byte_amount <= '0;
        i_block_amount <= '0;
        i_materialized_size <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed plan, budget starts at its reset value of zero
        // zero charge fits a zero budget, a one-byte charge does not
        plan.push_back(record_row(1'b1, 11'd5, 64'd0, 64'd0, 64'd0,
                                  pba_pkg::ST_OK, 64'd0, 64'd0, 64'd0, 1));
        plan.push_back(record_row(1'b1, 11'd5, 64'd1, 64'd0, 64'd0,
                                  pba_pkg::ST_BUDGET, 64'd0, 64'd0, 64'd0, 1));
        // all fields at their top: no carry, but over budget
        plan.push_back(record_row(1'b1, 11'd2047, ALL_ONES, ALL_ONES, ALL_ONES,
                                  pba_pkg::ST_BUDGET, 64'd0, 64'd0, 64'd0, 1));
        plan.push_back(budget_row(ALL_ONES));
        plan.push_back(record_row(1'b1, 11'd0, 64'd1, 64'd1, 64'd1,
                                  pba_pkg::ST_OK, 64'd1, 64'd1, 64'd1, 2));
        // byte carry out
        plan.push_back(record_row(1'b1, 11'd2047, ALL_ONES, 64'd0, 64'd0,
                                  pba_pkg::ST_OVERFLOW, 64'd1, 64'd1, 64'd1, 2));
        // block carry out
        plan.push_back(record_row(1'b1, 11'd9, 64'd0, ALL_ONES, 64'd5,
                                  pba_pkg::ST_OVERFLOW, 64'd1, 64'd1, 64'd1, 2));
        // known identifier: totals move, count does not
        plan.push_back(record_row(1'b1, 11'd0, 64'd2, 64'd3, 64'd0,
                                  pba_pkg::ST_OK, 64'd3, 64'd4, 64'd1, 2));
        plan.push_back(budget_row(64'd10));
        // total lands exactly on the budget
        plan.push_back(record_row(1'b1, 11'd1024, 64'd7, 64'd0, 64'd40,
                                  pba_pkg::ST_OK, 64'd10, 64'd4, 64'd40, 3));
        // over budget outranks block carry
        plan.push_back(record_row(1'b1, 11'd1024, 64'd1, ALL_ONES, 64'd0,
                                  pba_pkg::ST_BUDGET, 64'd10, 64'd4, 64'd40, 3));
        // smaller size leaves the peak alone
        plan.push_back(record_row(1'b1, 11'd1, 64'd0, 64'd5, 64'd39,
                                  pba_pkg::ST_OK, 64'd10, 64'd9, 64'd40, 4));
        // budget dropped below the total rejects even a zero charge
        plan.push_back(budget_row(64'd0));
        plan.push_back(record_row(1'b1, 11'd3, 64'd0, 64'd0, 64'd0,
                                  pba_pkg::ST_BUDGET, 64'd10, 64'd9, 64'd40, 4));
        plan.push_back(budget_row(64'h5555_5555_5555_5555));
        plan.push_back(record_row(1'b0, 11'h555, 64'h2AAA_AAAA_AAAA_AAAA,
                                  64'h2AAA_AAAA_AAAA_AAAA, 64'h0000_0000_00AA_AAAA,
                                  pba_pkg::ST_OK, 64'd0, 64'd0, 64'd0, 0));
        plan.push_back(record_row(1'b0, 11'h2AA, 64'h1111_1111_1111_1111, 64'd0,
                                  64'h0000_0000_0F0F_0F0F, pba_pkg::ST_OK,
                                  64'd0, 64'd0, 64'd0, 0));

        idle_on = 1'b1;
        foreach (plan[i]) begin
            if (plan[i].kind == ROW_BUDGET) begin
                write_budget(plan[i].budget);
            end else begin
                offer_record(plan[i].rec, plan[i].typed, plan[i].want);
                idle_gap();
            end
        end

        // random phases, each under its own budget
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin mode = BUD_MAX;      n_items = 150; end
                1: begin mode = BUD_MAX;      n_items = 150; end
                2: begin mode = BUD_HEADROOM; n_items = 150; end
                3: begin mode = BUD_EXACT;    n_items = 60;  end
                4: begin mode = BUD_MAX;      n_items = 150; end
                5: begin mode = BUD_RANDOM;   n_items = 80;  end
                6: begin mode = BUD_HEADROOM; n_items = 150; end
                7: begin mode = BUD_ZERO;     n_items = 40;  end
                8: begin mode = BUD_MAX;      n_items = 170; end
                default: begin mode = BUD_MAX; n_items = 150; end
            endcase
            case (mode)
                BUD_MAX:      new_budget = ALL_ONES;
                BUD_HEADROOM: new_budget = charged_bytes + (64'($urandom) << $urandom_range(0, 10));
                BUD_EXACT:    new_budget = charged_bytes;
                BUD_RANDOM:   new_budget = rand64();
                default:      new_budget = '0;
            endcase
            write_budget(new_budget);
            idle_on = (p != 1 && p != 4 && p != NUM_PHASES - 1);
            // long result hold-off while records keep coming
            if (p == 1) hold_rx_req = 1'b1;
            for (int n = 0; n < n_items; n++) begin
                if (p == NUM_PHASES - 1 && n == 100) begin
                    // drive every total and the peak to all ones
                    a.tensor_id = id_list[0];
                    a.byte_amount = ~charged_bytes;
                    a.block_amount = ~charged_blocks;
                    a.materialized_size = ALL_ONES;
                end else begin
                    a = make_access();
                end
                offer_record(a, 1'b0, none);
                idle_gap();
            end
        end

        // wait for the last results, then a full scan's worth of quiet
        i_valid <= 1'b0;
        wait_cycles = 0;
        while (pending_tallies.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (MAX_IDS + 16) @(posedge i_clk);
        if (pending_tallies.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, pending_tallies.size());
            fail_count++;
        end

        $display("run covered %0d records and %0d checked results, %0d distinct ids stored",
                 records_sent, results_checked, id_count);
        $display("status ok %0d, overflow %0d, budget %0d, capacity %0d; input stalled %0d cycles",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 input_stall_cycles);
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // watchdog
    initial begin : watchdog
        #8000000;
        $display("%0t: run did not finish in time", $time);
        $display("FAILED: results differ");
        $finish;
    end

endmodule

FILE: payload_budget_accounting.f
hw/rtl/pba_pkg.sv
hw/rtl/pba_ram.sv
hw/rtl/pba_ctrl.sv
hw/rtl/pba_dp.sv
hw/rtl/payload_budget_accounting.sv
tb/payload_budget_accounting_test.sv
